// ===== design/mandelbrot_escape_time_pixel_macros.svh =====
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define MBET_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbet assertion failed");

// Next-cycle implication, checked while out of reset.
`define MBET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbet assertion failed");

`endif

// ===== design/mbet_pkg.sv =====
`default_nettype none

package mbet_pkg;

    localparam int COORD_W = 12;
    localparam int CFG_W   = 32;
    localparam int ITER_W  = 16;
    localparam int COLOR_W = 24;
    localparam int CIDX_W  = 3;
    // c = min + col*step: 13-bit signed times 32-bit signed, plus 32-bit
    localparam int C_W     = CFG_W + COORD_W + 2;

    localparam logic [CIDX_W-1:0] REG_X_MIN    = 3'd0;
    localparam logic [CIDX_W-1:0] REG_Y_MIN    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_X_STEP   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MAX_ITER = 3'd4;

    localparam logic [CFG_W-1:0]  RST_X_MIN    = 32'hE000_0000;
    localparam logic [CFG_W-1:0]  RST_Y_MIN    = 32'hE000_0000;
    localparam logic [CFG_W-1:0]  RST_X_STEP   = 32'd1073742;
    localparam logic [CFG_W-1:0]  RST_Y_STEP   = 32'd1073742;
    localparam logic [ITER_W-1:0] RST_MAX_ITER = 16'd1000;

    typedef struct packed {
        logic signed [CFG_W-1:0] x_min;
        logic signed [CFG_W-1:0] y_min;
        logic signed [CFG_W-1:0] x_step;
        logic signed [CFG_W-1:0] y_step;
        logic [ITER_W-1:0]       max_iter;
    } cfg_t;

    typedef struct packed {
        logic              done;
        logic [ITER_W-1:0] count;
    } iter_stat_t;

    typedef struct packed {
        logic               done;
        logic [COLOR_W-1:0] quot;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== design/mbet_div.sv =====
`default_nettype none

// Restoring divider: floor((2^24 - 1) * n / den), one quotient bit per cycle.
module mbet_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [mbet_pkg::ITER_W-1:0] n,
    input  wire logic [mbet_pkg::ITER_W-1:0] den,
    output mbet_pkg::div_stat_t             stat
);

    localparam int DW  = mbet_pkg::ITER_W;
    localparam int QW  = mbet_pkg::COLOR_W;
    localparam int NW  = DW + QW;
    localparam int CNT_W = $clog2(QW);

    logic [NW-1:0]    num;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    rem_next;
    logic [QW-1:0]    q_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             ge;

    // n * (2^24 - 1) without a multiplier
    assign num = {n, {QW{1'b0}}} - {{QW{1'b0}}, n};

    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[QW-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        diff     = rem_sh - {1'b0, den_reg};
        rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (den == '0)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient is known to fit in 24 bits, so the top 16 bits seed the remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            if (den == '0)
            begin
                rem_reg <= '0;
                q_reg   <= '0;
            end
            else
            begin
                rem_reg <= num[NW-1:QW];
                q_reg   <= num[QW-1:0];
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    assign stat.done = done_reg;
    assign stat.quot = q_reg;

endmodule

`default_nettype wire

// ===== design/mbet_iter.sv =====
`default_nettype none

// Escape-time loop: map the pixel to c, then alternate a multiply phase (limit and range
// check, x^2, y^2, 2xy) and an update phase (escape test, z = z^2 + c).
module mbet_iter #(
    parameter int FRAC_BITS = 28
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [mbet_pkg::COORD_W-1:0] col,
    input  wire logic [mbet_pkg::COORD_W-1:0] row,
    input  wire mbet_pkg::cfg_t               cfg,
    output mbet_pkg::iter_stat_t              stat
);

    localparam int CW  = mbet_pkg::C_W;
    localparam int PRW = mbet_pkg::CFG_W + mbet_pkg::COORD_W + 1;
    // z can reach |c| + 8*2^FRAC_BITS after the last update
    localparam int ZW  = ((FRAC_BITS + 5 > CW) ? FRAC_BITS + 5 : CW) + 1;
    // operands are within +-2*2^FRAC_BITS once the magnitude check passes
    localparam int OW  = FRAC_BITS + 3;
    localparam int PW  = 2 * OW;
    localparam int SQW = FRAC_BITS + 3;
    localparam int XYW = FRAC_BITS + 5;

    localparam logic signed [ZW-1:0] LIM =
        $signed({{(ZW - FRAC_BITS - 2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}});
    localparam logic signed [ZW-1:0] NLIM = -LIM;
    localparam logic [SQW:0] FOUR = {2'b01, {(SQW - 1){1'b0}}};

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_MAP  = 4'b0010,
        PH_MUL  = 4'b0100,
        PH_UPD  = 4'b1000
    } phase_t;

    phase_t                         phase_reg;
    logic                           done_reg;
    logic [mbet_pkg::ITER_W-1:0]    n_reg;
    logic [mbet_pkg::COORD_W-1:0]   col_reg;
    logic [mbet_pkg::COORD_W-1:0]   row_reg;
    logic signed [CW-1:0]           cr_reg;
    logic signed [CW-1:0]           ci_reg;
    logic signed [ZW-1:0]           x_reg;
    logic signed [ZW-1:0]           y_reg;
    logic [SQW-1:0]                 x2_reg;
    logic [SQW-1:0]                 y2_reg;
    logic signed [XYW-1:0]          xy_reg;

    logic signed [PRW-1:0]          prod_r;
    logic signed [PRW-1:0]          prod_i;
    logic signed [CW-1:0]           cr_next;
    logic signed [CW-1:0]           ci_next;
    logic signed [OW-1:0]           xo;
    logic signed [OW-1:0]           yo;
    logic signed [PW-1:0]           p_xx;
    logic signed [PW-1:0]           p_yy;
    logic signed [PW-1:0]           p_xy;
    logic [SQW:0]                   mag2;
    logic                           big;
    logic                           limit_hit;
    logic                           escaped;
    logic signed [ZW-1:0]           x_next;
    logic signed [ZW-1:0]           y_next;

    always_comb
    begin
        prod_r  = PRW'($signed({1'b0, col_reg})) * PRW'(cfg.x_step);
        prod_i  = PRW'($signed({1'b0, row_reg})) * PRW'(cfg.y_step);
        cr_next = CW'(cfg.x_min) + CW'(prod_r);
        ci_next = CW'(cfg.y_min) + CW'(prod_i);

        xo   = x_reg[OW-1:0];
        yo   = y_reg[OW-1:0];
        p_xx = PW'(xo) * PW'(xo);
        p_yy = PW'(yo) * PW'(yo);
        p_xy = PW'(xo) * PW'(yo);

        big       = (x_reg > LIM) || (x_reg < NLIM) || (y_reg > LIM) || (y_reg < NLIM);
        limit_hit = n_reg >= cfg.max_iter;

        mag2    = {1'b0, x2_reg} + {1'b0, y2_reg};
        escaped = mag2 > FOUR;
        x_next  = ZW'($signed({1'b0, x2_reg})) - ZW'($signed({1'b0, y2_reg})) + ZW'(cr_reg);
        y_next  = ZW'(xy_reg) + ZW'(ci_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            n_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= '0;
                        phase_reg <= PH_MAP;
                    end
                end
                PH_MAP:
                begin
                    phase_reg <= PH_MUL;
                end
                PH_MUL:
                begin
                    // stop on the limit or on a component beyond 2 before squaring
                    if (limit_hit || big)
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= PH_IDLE;
                    end
                    else
                        phase_reg <= PH_UPD;
                end
                PH_UPD:
                begin
                    if (escaped)
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= PH_IDLE;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        phase_reg <= PH_MUL;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            col_reg <= col;
            row_reg <= row;
        end
        if (phase_reg == PH_MAP)
        begin
            cr_reg <= cr_next;
            ci_reg <= ci_next;
            x_reg  <= ZW'(cr_next);
            y_reg  <= ZW'(ci_next);
        end
        if (phase_reg == PH_MUL)
        begin
            // floor shifts of the signed products
            x2_reg <= p_xx[2*FRAC_BITS+2:FRAC_BITS];
            y2_reg <= p_yy[2*FRAC_BITS+2:FRAC_BITS];
            xy_reg <= p_xy[2*FRAC_BITS+3:FRAC_BITS-1];
        end
        if (phase_reg == PH_UPD && !escaped)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign stat.done  = done_reg;
    assign stat.count = n_reg;

endmodule

`default_nettype wire

// ===== design/mandelbrot_escape_time_pixel.sv =====
// Flow: the pixel beat is mapped to c, then the loop alternates a multiply step and an
//   update step until the limit or a component beyond 2 stops it at a multiply step, or
//   the squared magnitude at an update step; the divider then derives the color.
// One pixel at a time: the input stalls from the taken beat until the result is loaded
//   into the output register, which waits while a stalled result beat still occupies it.
// Reset (rst_n low, asynchronous) empties the pipe and loads the register defaults.
`default_nettype none

module mandelbrot_escape_time_pixel #(
    parameter int FRAC_BITS = 28,
    parameter int MAX_DIM   = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pix_valid,
    output logic                               pix_stall,
    input  wire logic [mbet_pkg::COORD_W-1:0]  col,
    input  wire logic [mbet_pkg::COORD_W-1:0]  row,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic [mbet_pkg::ITER_W-1:0]        iterations,
    output logic [mbet_pkg::COLOR_W-1:0]       color,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mbet_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [mbet_pkg::CFG_W-1:0]    cfg_data
);

    localparam int DIM_W = 17;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ITER = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t                        state_reg;
    mbet_pkg::cfg_t                cfg_reg;
    mbet_pkg::iter_stat_t          iter_stat;
    mbet_pkg::div_stat_t           div_stat;
    logic [mbet_pkg::ITER_W-1:0]   n_reg;
    logic [mbet_pkg::ITER_W-1:0]   iterations_reg;
    logic [mbet_pkg::COLOR_W-1:0]  color_reg;
    logic                          res_valid_reg;
    logic [mbet_pkg::COORD_W-1:0]  col_sat;
    logic [mbet_pkg::COORD_W-1:0]  row_sat;
    logic                          pix_take;
    logic                          res_load;

    assign cfg_ready = 1'b1;
    assign pix_stall = state_reg != ST_IDLE;
    assign pix_take  = pix_valid && !pix_stall;
    assign res_load  = (state_reg == ST_HOLD) && (!res_valid_reg || !res_stall);

    // clamp indices beyond the image to its last row or column
    assign col_sat = ({{(DIM_W - mbet_pkg::COORD_W){1'b0}}, col} >= DIM_W'(MAX_DIM)) ?
                     mbet_pkg::COORD_W'(MAX_DIM - 1) : col;
    assign row_sat = ({{(DIM_W - mbet_pkg::COORD_W){1'b0}}, row} >= DIM_W'(MAX_DIM)) ?
                     mbet_pkg::COORD_W'(MAX_DIM - 1) : row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min    <= mbet_pkg::RST_X_MIN;
            cfg_reg.y_min    <= mbet_pkg::RST_Y_MIN;
            cfg_reg.x_step   <= mbet_pkg::RST_X_STEP;
            cfg_reg.y_step   <= mbet_pkg::RST_Y_STEP;
            cfg_reg.max_iter <= mbet_pkg::RST_MAX_ITER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mbet_pkg::REG_X_MIN:    cfg_reg.x_min    <= cfg_data;
                mbet_pkg::REG_Y_MIN:    cfg_reg.y_min    <= cfg_data;
                mbet_pkg::REG_X_STEP:   cfg_reg.x_step   <= cfg_data;
                mbet_pkg::REG_Y_STEP:   cfg_reg.y_step   <= cfg_data;
                mbet_pkg::REG_MAX_ITER: cfg_reg.max_iter <= cfg_data[mbet_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (pix_take)
                        state_reg <= ST_ITER;
                end
                ST_ITER:
                begin
                    if (iter_stat.done)
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                        state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    // hold until the output register frees up
                    if (res_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ITER && iter_stat.done)
            n_reg <= iter_stat.count;
        if (res_load)
        begin
            iterations_reg <= n_reg;
            color_reg      <= div_stat.quot;
        end
    end

    mbet_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pix_take),
        .col   (col_sat),
        .row   (row_sat),
        .cfg   (cfg_reg),
        .stat  (iter_stat)
    );

    mbet_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_ITER && iter_stat.done),
        .n     (iter_stat.count),
        .den   (cfg_reg.max_iter),
        .stat  (div_stat)
    );

    assign res_valid  = res_valid_reg;
    assign iterations = iterations_reg;
    assign color      = color_reg;

endmodule

`default_nettype wire

// ===== design/mbet_chk.sv =====
`default_nettype none
`include "mandelbrot_escape_time_pixel_macros.svh"

module mbet_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pix_valid,
    input wire logic                          pix_stall,
    input wire logic                          res_valid,
    input wire logic                          res_stall,
    input wire logic [mbet_pkg::ITER_W-1:0]   iterations,
    input wire logic [mbet_pkg::COLOR_W-1:0]  color
);

    // a stalled result beat holds
    `MBET_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall,
        res_valid && $stable(iterations) && $stable(color))

    // one pixel at a time: a taken beat closes the input
    `MBET_ASSERT_NEXT(a_pix_busy, clk, rst_n, pix_valid && !pix_stall, pix_stall)

    // zero iterations always map to black
    `MBET_ASSERT_NOW(a_zero_black, clk, rst_n, res_valid && (iterations == '0), color == '0)

    // results appear only from a pixel in flight
    `MBET_ASSERT_NOW(a_res_source, clk, rst_n, $rose(res_valid), $past(pix_stall))

endmodule

bind mandelbrot_escape_time_pixel mbet_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .iterations (iterations),
    .color      (color)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import mbet_pkg::*;

    localparam int FRAC_BITS = 28;
    localparam int MAX_DIM   = 4096;
    localparam longint ESC_LIMIT = longint'(2) << FRAC_BITS;
    localparam longint ESC_FOUR  = longint'(4) << FRAC_BITS;
    localparam logic [CIDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CIDX_W-1:0] REG_SPARE_LAST  = 3'd7;
    localparam int END_SLACK   = 64;
    localparam int RAND_PHASES = 8;
    localparam int PER_PHASE   = 75;

    typedef struct packed {
        logic [ITER_W-1:0]  iterations;
        logic [COLOR_W-1:0] color;
    } pixel_result_t;

    logic                clk;
    logic                rst_n;
    logic                pix_valid;
    logic                pix_stall;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic                res_valid;
    logic                res_stall;
    logic [ITER_W-1:0]   iterations;
    logic [COLOR_W-1:0]  color;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    cfg_t          window_regs;
    pixel_result_t pending_pixels[$];
    pixel_result_t oldest;
    int            mismatches;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    int            hold_left;

    mandelbrot_escape_time_pixel #(
        .FRAC_BITS(FRAC_BITS),
        .MAX_DIM  (MAX_DIM)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .col       (col),
        .row       (row),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .iterations(iterations),
        .color     (color),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(64'd100_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic pixel_result_t escape_time(input logic [COORD_W-1:0] px,
                                                  input logic [COORD_W-1:0] py);
        longint           ucol, urow;
        longint           cr, ci, zr, zi, zr2, zi2, zri;
        int unsigned      n;
        longint unsigned  shade;
        pixel_result_t    r;
        ucol = px;
        urow = py;
        if (ucol >= MAX_DIM)
            ucol = MAX_DIM - 1;
        if (urow >= MAX_DIM)
            urow = MAX_DIM - 1;
        cr = longint'($signed(window_regs.x_min)) + ucol * longint'($signed(window_regs.x_step));
        ci = longint'($signed(window_regs.y_min)) + urow * longint'($signed(window_regs.y_step));
        zr = cr;
        zi = ci;
        n  = 0;
        while (n < window_regs.max_iter)
        begin
            // a component past 2 escapes before it is squared
            if ((zr < 0 ? -zr : zr) > ESC_LIMIT || (zi < 0 ? -zi : zi) > ESC_LIMIT)
                break;
            zr2 = (zr * zr) >>> FRAC_BITS;
            zi2 = (zi * zi) >>> FRAC_BITS;
            if (zr2 + zi2 > ESC_FOUR)
                break;
            zri = (zr * zi) >>> (FRAC_BITS - 1);
            zr  = zr2 - zi2 + cr;
            zi  = zri + ci;
            n++;
        end
        shade = 0;
        if (window_regs.max_iter != 0)
            shade = (64'hFF_FFFF * n) / window_regs.max_iter;
        r.iterations = n[ITER_W-1:0];
        r.color      = shade[COLOR_W-1:0];
        return r;
    endfunction

    // Receiver: long hold-off first, otherwise random stalls.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result beat iterations %0d color %06h",
                         $time, iterations, color);
                mismatches++;
            end
            else
            begin
                oldest = pending_pixels.pop_front();
                if (iterations !== oldest.iterations)
                begin
                    $display("%0t: iterations expected %0d actual %0d",
                             $time, oldest.iterations, iterations);
                    mismatches++;
                end
                if (color !== oldest.color)
                begin
                    $display("%0t: color expected %06h actual %06h",
                             $time, oldest.color, color);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        col       <= px;
        row       <= py;
        do
            @(posedge clk);
        while (pix_stall);
        pending_pixels.push_back(escape_time(px, py));
    endtask

    task automatic drain_results();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_X_MIN:    window_regs.x_min    = value;
            REG_Y_MIN:    window_regs.y_min    = value;
            REG_X_STEP:   window_regs.x_step   = value;
            REG_Y_STEP:   window_regs.y_step   = value;
            REG_MAX_ITER: window_regs.max_iter = value[ITER_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_window(input logic [CFG_W-1:0] xmin, input logic [CFG_W-1:0] ymin,
                                input logic [CFG_W-1:0] xstep, input logic [CFG_W-1:0] ystep,
                                input logic [CFG_W-1:0] limit_word);
        drain_results();
        write_reg(REG_X_MIN, xmin);
        write_reg(REG_Y_MIN, ymin);
        write_reg(REG_X_STEP, xstep);
        write_reg(REG_Y_STEP, ystep);
        write_reg(REG_MAX_ITER, limit_word);
    endtask

    // Window over the interesting part of the plane, or raw noise.
    task automatic pick_window(input bit noisy, input logic [CFG_W-1:0] limit_word);
        int x0, y0, sx, sy;
        if (noisy)
        begin
            write_window($urandom(), $urandom(), $urandom(), $urandom(), limit_word);
        end
        else
        begin
            x0 = -603979776 + int'($urandom_range(0, 201326592));
            y0 = -402653184 + int'($urandom_range(0, 201326592));
            sx = $urandom_range(16384, 196608);
            sy = $urandom_range(16384, 196608);
            // walk the same window backwards
            if ($urandom_range(1))
            begin
                x0 = x0 + 4095 * sx;
                sx = -sx;
            end
            if ($urandom_range(1))
            begin
                y0 = y0 + 4095 * sy;
                sy = -sy;
            end
            write_window(x0, y0, sx, sy, limit_word);
        end
    endtask

    task automatic set_idling(input int sender_pct, input int stall_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = stall_pct;
    endtask

    task automatic test_reset_defaults();
        set_idling(0, 0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd500, 12'd500);
        send_pixel(12'd500, 12'd0);
    endtask

    task automatic test_escape_boundary();
        set_idling(28, 28);
        // |z| exactly 2 passes once, then escapes; c = -2 stays at 2 up to the limit
        write_window(32'h2000_0000, 32'h0, 32'h0, 32'h0, 32'd1000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        write_window(32'h2000_0001, 32'h0, 32'h0, 32'h0, 32'd1000);
        send_pixel(12'd0, 12'd0);
        write_window(32'hE000_0000, 32'h0, 32'h0, 32'h0, 32'd1000);
        send_pixel(12'd7, 12'd9);
        write_window(32'h0, 32'hE000_0000, 32'h0, 32'h0, 32'd1000);
        send_pixel(12'd0, 12'd0);
    endtask

    task automatic test_register_extremes();
        set_idling(0, 67);
        write_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd1, 12'd4095);
    endtask

    task automatic test_zero_limit();
        set_idling(67, 0);
        write_window(32'h0, 32'h0, 32'h0, 32'h0, 32'hABCD_0000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
    endtask

    task automatic test_unknown_index();
        set_idling(0, 0);
        write_window(32'hF000_0000, 32'h0, 32'd65536, 32'd65536, 32'd40);
        for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
            write_reg(i[CIDX_W-1:0], $urandom());
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd1024);
    endtask

    task automatic test_full_limit();
        set_idling(0, 0);
        write_window(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
        send_pixel(12'd0, 12'd0);
        write_window(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0001);
        send_pixel(12'd0, 12'd0);
    endtask

    task automatic test_output_hold_off();
        set_idling(0, 0);
        pick_window(1'b0, 32'd4);
        hold_left = 800;
        for (int i = 0; i < 24; i++)
            send_pixel($urandom(), $urandom());
    endtask

    task automatic test_drain_resume();
        set_idling(28, 28);
        pick_window(1'b0, 32'd8);
        for (int i = 0; i < 10; i++)
            send_pixel($urandom(), $urandom());
        drain_results();
        for (int i = 0; i < 10; i++)
            send_pixel($urandom(), $urandom());
    endtask

    task automatic test_random_windows();
        int sender_mix[4];
        int stall_mix[4];
        logic [CFG_W-1:0] limit_word;
        sender_mix = '{0, 67, 0, 28};
        stall_mix  = '{0, 0, 67, 28};
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            limit_word = ($urandom() & 32'hFFFF_0000) | $urandom_range(2, 200);
            if (p == 5)
                limit_word = 32'd1000;
            else if (p == 7)
                limit_word = ($urandom() & 32'hFFFF_0000) | $urandom_range(1, 16);
            pick_window(p == 3 || p == 6, limit_word);
            set_idling(sender_mix[p % 4], stall_mix[p % 4]);
            for (int i = 0; i < PER_PHASE; i++)
                send_pixel($urandom(), $urandom());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        pix_valid   = 1'b0;
        col         = '0;
        row         = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_X_MIN;
        cfg_data    = '0;
        mismatches  = 0;
        hold_left   = 0;
        window_regs = '{x_min: RST_X_MIN, y_min: RST_Y_MIN, x_step: RST_X_STEP,
                        y_step: RST_Y_STEP, max_iter: RST_MAX_ITER};
        set_idling(0, 0);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_escape_boundary();
        test_register_extremes();
        test_zero_limit();
        test_unknown_index();
        test_output_hold_off();
        test_drain_resume();
        test_full_limit();
        test_random_windows();

        drain_results();
        repeat (END_SLACK) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
